[design/lralu_pkg.sv]
// Shared types and constants for the 8/16-bit ALU with a persistent flag register.
// Holds the operation codes, the beat structs of both channels and the flag struct.
// No dependencies.
package lralu_pkg;

	typedef enum logic [5:0] {
		OP_ADD    = 6'd0,
		OP_ADC    = 6'd1,
		OP_SUB    = 6'd2,
		OP_SBC    = 6'd3,
		OP_AND    = 6'd4,
		OP_XOR    = 6'd5,
		OP_OR     = 6'd6,
		OP_CP     = 6'd7,
		OP_INC8   = 6'd8,
		OP_DEC8   = 6'd9,
		OP_RLCA   = 6'd10,
		OP_RRCA   = 6'd11,
		OP_RLA    = 6'd12,
		OP_RRA    = 6'd13,
		OP_RLC    = 6'd14,
		OP_RRC    = 6'd15,
		OP_RL     = 6'd16,
		OP_RR     = 6'd17,
		OP_SLA    = 6'd18,
		OP_SRA    = 6'd19,
		OP_SWAP   = 6'd20,
		OP_SRL    = 6'd21,
		OP_BIT    = 6'd22,
		OP_RES    = 6'd23,
		OP_SET    = 6'd24,
		OP_DAA    = 6'd25,
		OP_CPL    = 6'd26,
		OP_SCF    = 6'd27,
		OP_CCF    = 6'd28,
		OP_ADD16  = 6'd29,
		OP_ADDSP  = 6'd30,
		OP_INC16  = 6'd31,
		OP_DEC16  = 6'd32
	} op_t;

	localparam logic [7:0] DAA_LOW_ADJ  = 8'h06;
	localparam logic [7:0] DAA_HIGH_ADJ = 8'h60;
	localparam logic [7:0] DAA_BCD_MAX  = 8'h99;
	localparam logic [3:0] DAA_DIGIT_MAX = 4'h9;

	typedef struct packed {
		logic z;
		logic n;
		logic h;
		logic c;
	} flags_t;

	typedef struct packed {
		logic [5:0]  operation;
		logic [15:0] first_operand;
		logic [15:0] second_operand;
		logic [2:0]  bit_index;
	} in_item_t;

	typedef struct packed {
		logic [15:0] result;
		logic        zero_flag;
		logic        subtract_flag;
		logic        half_carry_flag;
		logic        carry_flag;
	} out_item_t;

endpackage

[design/lralu_core.sv]
// Combinational ALU datapath: one operation against the current flags.
// Produces the written-back value and the new Z, N, H and C flags.
// Depends on lralu_pkg.
module lralu_core (
	input  lralu_pkg::in_item_t  item,
	input  lralu_pkg::flags_t    flags_cur,
	output lralu_pkg::out_item_t res
);

	always_comb begin
		logic [7:0]  a;
		logic [7:0]  b;
		logic [15:0] x;
		logic [15:0] y;
		logic        ci;
		logic        k;
		logic [8:0]  sum9;
		logic [4:0]  nib5;
		logic [8:0]  diff9;
		logic [7:0]  r8;
		logic [15:0] r16;
		logic [16:0] sum17;
		logic [12:0] sum13;
		logic [7:0]  dv;
		logic        dc;
		logic        eight_bit;
		lralu_pkg::flags_t fl;

		a     = item.first_operand[7:0];
		b     = item.second_operand[7:0];
		x     = item.first_operand;
		y     = item.second_operand;
		ci    = flags_cur.c;
		k     = 1'b0;
		sum9  = '0;
		nib5  = '0;
		diff9 = '0;
		r8    = a;
		r16   = x;
		sum17 = '0;
		sum13 = '0;
		dv    = a;
		dc    = ci;
		eight_bit = 1'b0;
		fl    = flags_cur;

		unique case (lralu_pkg::op_t'(item.operation))
			lralu_pkg::OP_ADD, lralu_pkg::OP_ADC: begin
				k = (lralu_pkg::op_t'(item.operation) == lralu_pkg::OP_ADC) ? ci : 1'b0;
				sum9 = {1'b0, a} + {1'b0, b} + {8'b0, k};
				nib5 = {1'b0, a[3:0]} + {1'b0, b[3:0]} + {4'b0, k};
				r8 = sum9[7:0];
				eight_bit = 1'b1;
				fl.z = (r8 == 8'h00);
				fl.n = 1'b0;
				fl.h = nib5[4];
				fl.c = sum9[8];
			end
			lralu_pkg::OP_SUB, lralu_pkg::OP_SBC, lralu_pkg::OP_CP: begin
				k = (lralu_pkg::op_t'(item.operation) == lralu_pkg::OP_SBC) ? ci : 1'b0;
				diff9 = {1'b0, a} - {1'b0, b} - {8'b0, k};
				nib5 = {1'b0, a[3:0]} - {1'b0, b[3:0]} - {4'b0, k};
				r8 = diff9[7:0];
				// Compare only sets flags; the operand comes back untouched.
				eight_bit = (lralu_pkg::op_t'(item.operation) != lralu_pkg::OP_CP);
				fl.z = (diff9[7:0] == 8'h00);
				fl.n = 1'b1;
				fl.h = nib5[4];
				fl.c = diff9[8];
			end
			lralu_pkg::OP_AND: begin
				r8 = a & b;
				eight_bit = 1'b1;
				fl = '{z: (r8 == 8'h00), n: 1'b0, h: 1'b1, c: 1'b0};
			end
			lralu_pkg::OP_XOR: begin
				r8 = a ^ b;
				eight_bit = 1'b1;
				fl = '{z: (r8 == 8'h00), n: 1'b0, h: 1'b0, c: 1'b0};
			end
			lralu_pkg::OP_OR: begin
				r8 = a | b;
				eight_bit = 1'b1;
				fl = '{z: (r8 == 8'h00), n: 1'b0, h: 1'b0, c: 1'b0};
			end
			lralu_pkg::OP_INC8: begin
				r8 = a + 8'd1;
				eight_bit = 1'b1;
				fl.z = (r8 == 8'h00);
				fl.n = 1'b0;
				fl.h = (r8[3:0] == 4'h0);
			end
			lralu_pkg::OP_DEC8: begin
				r8 = a - 8'd1;
				eight_bit = 1'b1;
				fl.z = (r8 == 8'h00);
				fl.n = 1'b1;
				fl.h = (a[3:0] == 4'h0);
			end
			lralu_pkg::OP_RLCA, lralu_pkg::OP_RLC: begin
				r8 = {a[6:0], a[7]};
				eight_bit = 1'b1;
				fl = '{z: 1'b0, n: 1'b0, h: 1'b0, c: a[7]};
				if (lralu_pkg::op_t'(item.operation) == lralu_pkg::OP_RLC) begin
					fl.z = (r8 == 8'h00);
				end
			end
			lralu_pkg::OP_RRCA, lralu_pkg::OP_RRC: begin
				r8 = {a[0], a[7:1]};
				eight_bit = 1'b1;
				fl = '{z: 1'b0, n: 1'b0, h: 1'b0, c: a[0]};
				if (lralu_pkg::op_t'(item.operation) == lralu_pkg::OP_RRC) begin
					fl.z = (r8 == 8'h00);
				end
			end
			lralu_pkg::OP_RLA, lralu_pkg::OP_RL: begin
				r8 = {a[6:0], ci};
				eight_bit = 1'b1;
				fl = '{z: 1'b0, n: 1'b0, h: 1'b0, c: a[7]};
				if (lralu_pkg::op_t'(item.operation) == lralu_pkg::OP_RL) begin
					fl.z = (r8 == 8'h00);
				end
			end
			lralu_pkg::OP_RRA, lralu_pkg::OP_RR: begin
				r8 = {ci, a[7:1]};
				eight_bit = 1'b1;
				fl = '{z: 1'b0, n: 1'b0, h: 1'b0, c: a[0]};
				if (lralu_pkg::op_t'(item.operation) == lralu_pkg::OP_RR) begin
					fl.z = (r8 == 8'h00);
				end
			end
			lralu_pkg::OP_SLA: begin
				r8 = {a[6:0], 1'b0};
				eight_bit = 1'b1;
				fl = '{z: (r8 == 8'h00), n: 1'b0, h: 1'b0, c: a[7]};
			end
			lralu_pkg::OP_SRA: begin
				r8 = {a[7], a[7:1]};
				eight_bit = 1'b1;
				fl = '{z: (r8 == 8'h00), n: 1'b0, h: 1'b0, c: a[0]};
			end
			lralu_pkg::OP_SRL: begin
				r8 = {1'b0, a[7:1]};
				eight_bit = 1'b1;
				fl = '{z: (r8 == 8'h00), n: 1'b0, h: 1'b0, c: a[0]};
			end
			lralu_pkg::OP_SWAP: begin
				r8 = {a[3:0], a[7:4]};
				eight_bit = 1'b1;
				fl = '{z: (r8 == 8'h00), n: 1'b0, h: 1'b0, c: 1'b0};
			end
			lralu_pkg::OP_BIT: begin
				fl.z = ~a[item.bit_index];
				fl.n = 1'b0;
				fl.h = 1'b1;
			end
			lralu_pkg::OP_RES: begin
				r8 = a;
				r8[item.bit_index] = 1'b0;
				eight_bit = 1'b1;
			end
			lralu_pkg::OP_SET: begin
				r8 = a;
				r8[item.bit_index] = 1'b1;
				eight_bit = 1'b1;
			end
			lralu_pkg::OP_DAA: begin
				// After a subtract the carry is kept and only the recorded
				// adjustments are taken back out.
				if (flags_cur.n) begin
					dv = a - (flags_cur.c ? lralu_pkg::DAA_HIGH_ADJ : 8'h00)
						- (flags_cur.h ? lralu_pkg::DAA_LOW_ADJ : 8'h00);
					dc = flags_cur.c;
				end else begin
					dc = flags_cur.c || (a > lralu_pkg::DAA_BCD_MAX);
					dv = a + (dc ? lralu_pkg::DAA_HIGH_ADJ : 8'h00)
						+ ((flags_cur.h || (a[3:0] > lralu_pkg::DAA_DIGIT_MAX))
							? lralu_pkg::DAA_LOW_ADJ : 8'h00);
				end
				r8 = dv;
				eight_bit = 1'b1;
				fl.z = (dv == 8'h00);
				fl.h = 1'b0;
				fl.c = dc;
			end
			lralu_pkg::OP_CPL: begin
				r8 = ~a;
				eight_bit = 1'b1;
				fl.n = 1'b1;
				fl.h = 1'b1;
			end
			lralu_pkg::OP_SCF: begin
				fl.n = 1'b0;
				fl.h = 1'b0;
				fl.c = 1'b1;
			end
			lralu_pkg::OP_CCF: begin
				fl.n = 1'b0;
				fl.h = 1'b0;
				fl.c = ~flags_cur.c;
			end
			lralu_pkg::OP_ADD16: begin
				sum17 = {1'b0, x} + {1'b0, y};
				sum13 = {1'b0, x[11:0]} + {1'b0, y[11:0]};
				r16 = sum17[15:0];
				fl.n = 1'b0;
				fl.h = sum13[12];
				fl.c = sum17[16];
			end
			lralu_pkg::OP_ADDSP: begin
				// H and C come from the unsigned low-byte add of the raw byte; Z and N are cleared.
				r16 = x + {{8{b[7]}}, b};
				sum9 = {1'b0, x[7:0]} + {1'b0, b};
				nib5 = {1'b0, x[3:0]} + {1'b0, b[3:0]};
				fl = '{z: 1'b0, n: 1'b0, h: nib5[4], c: sum9[8]};
			end
			lralu_pkg::OP_INC16: begin
				r16 = x + 16'd1;
			end
			lralu_pkg::OP_DEC16: begin
				r16 = x - 16'd1;
			end
			default: begin
				r16 = x;
			end
		endcase

		res.result          = eight_bit ? {8'h00, r8} : r16;
		res.zero_flag       = fl.z;
		res.subtract_flag   = fl.n;
		res.half_carry_flag = fl.h;
		res.carry_flag      = fl.c;
	end

endmodule

[design/cpu_alu_with_flags_unit.sv]
// ALU with Z/N/H/C flag register. An accepted op beat passes through the input register,
// then the result register, before its res beat; one beat per cycle is sustained while the
// res channel does not stall, since the flags feed back through one short combinational pass.
// Reset clears both valid bits and the flag register to zero.
// Depends on lralu_pkg and lralu_core.
module cpu_alu_with_flags_unit (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  op_valid,
	output logic                  op_ready,
	input  lralu_pkg::in_item_t   op,
	output logic                  res_valid,
	input  logic                  res_ready,
	output lralu_pkg::out_item_t  res
);

	logic                  valid_s1;
	lralu_pkg::in_item_t   item_s1;
	logic                  valid_s2;
	lralu_pkg::out_item_t  item_s2;
	lralu_pkg::flags_t     flags_q;
	lralu_pkg::out_item_t  core_res;
	logic                  advance;

	lralu_core u_core (
		.item      (item_s1),
		.flags_cur (flags_q),
		.res       (core_res)
	);

	// The input stage moves on whenever the result register is empty or drained.
	assign advance  = !valid_s2 || res_ready;
	assign op_ready = !valid_s1 || advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
			flags_q  <= '0;
		end else begin
			if (op_ready) begin
				valid_s1 <= op_valid;
			end
			if (advance) begin
				valid_s2 <= valid_s1;
			end
			if (advance && valid_s1) begin
				flags_q <= '{z: core_res.zero_flag, n: core_res.subtract_flag,
					h: core_res.half_carry_flag, c: core_res.carry_flag};
			end
		end
	end

	always_ff @(posedge clk) begin
		if (op_valid && op_ready) begin
			item_s1 <= op;
		end
		if (advance && valid_s1) begin
			item_s2 <= core_res;
		end
	end

	assign res_valid = valid_s2;
	assign res       = item_s2;

endmodule
